// ===== sv/preemptive_priority_scheduler_core_defines.svh =====
// Assertion macros shared by the scheduler RTL.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_CORE_DEFINES_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PPSC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PPSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/ppsc_pkg.sv =====
`timescale 1ns / 1ps

package ppsc_pkg;

   localparam int unsigned TIME_W = 32;
   localparam int unsigned SLOT_W = 4;

   // One row of the job table.
   typedef struct packed {
      logic        [15:0] arrival;
      logic        [15:0] burst;
      logic        [15:0] remaining;
      logic signed [15:0] prio;
   } job_type;

   localparam int unsigned JOB_W = $bits(job_type);

   typedef enum logic [2:0] {
      STATUS_LOADED    = 3'd0,
      STATUS_FULL      = 3'd1,
      STATUS_ZERO      = 3'd2,
      STATUS_IDLE      = 3'd3,
      STATUS_RAN       = 3'd4,
      STATUS_COMPLETED = 3'd5
   } status_type;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_TICK = 1'b1
   } cmd_type;

endpackage

// ===== sv/ppsc_ram.sv =====
`timescale 1ns / 1ps

module ppsc_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== sv/preemptive_priority_scheduler_core.sv =====
`timescale 1ns / 1ps
//  Channel  Direction  Transfer carries
//  req_*    in         one load or one tick command
//  rsp_*    out        one status result for each command
//
//  A load goes from S_IDLE straight to S_OUT; a tick passes S_SCAN over every loaded slot,
//  then S_EXEC, then S_WAIT when the running job finishes, then S_OUT.
//  The scan reads one table slot per cycle and compares it with the best so far.
//  Reset is synchronous and clears the counts, the clock and the done flags.
//  A command may transfer while the last result waits in the output register;
//  a stalled result holds the sequencer in its final state.

`include "preemptive_priority_scheduler_core_defines.svh"

module preemptive_priority_scheduler_core #(
   parameter int unsigned MAX_PROCS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [47:0]  req_tdata,   // arrival[15:0], burst[31:16], prio[47:32]
   input  logic         req_tuser,   // cmd[0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // slot[3:0], finish_time[35:4],
                                     // turnaround[67:36], wait_time[99:68],
                                     // all_done[100], zero[103:101]
   output logic [2:0]   rsp_tuser    // status[2:0]
);

   localparam int unsigned IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int unsigned CNT_W = $clog2(MAX_PROCS + 1);
   localparam int unsigned TW    = ppsc_pkg::TIME_W;
   localparam int unsigned SW    = ppsc_pkg::SLOT_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_EXEC,
      S_WAIT,
      S_OUT
   } state_type;

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       job_cnt_ff, job_cnt_in;
   logic [CNT_W-1:0]       done_cnt_ff, done_cnt_in;
   logic [TW-1:0]          now_ff, now_in;
   logic [TW-1:0]          nxt_ff, nxt_in;
   logic [MAX_PROCS-1:0]   done_ff, done_in;
   logic [CNT_W-1:0]       scan_ff, scan_in;
   logic                   cmp_v_ff, cmp_v_in;
   logic [IDX_W-1:0]       cmp_idx_ff, cmp_idx_in;
   logic                   found_ff, found_in;
   logic [IDX_W-1:0]       best_idx_ff, best_idx_in;
   ppsc_pkg::job_type      best_ff, best_in;
   ppsc_pkg::status_type   res_status_ff, res_status_in;
   logic [IDX_W-1:0]       res_idx_ff, res_idx_in;
   logic [TW-1:0]          res_fin_ff, res_fin_in;
   logic [TW-1:0]          res_tat_ff, res_tat_in;
   logic [TW-1:0]          res_wt_ff, res_wt_in;
   logic                   rsp_tvalid_ff, rsp_tvalid_in;
   logic [103:0]           rsp_tdata_ff, rsp_tdata_in;
   logic [2:0]             rsp_tuser_ff, rsp_tuser_in;

   logic                   ram_wr_en;
   logic [IDX_W-1:0]       ram_wr_addr;
   ppsc_pkg::job_type      ram_wr_job;
   logic [IDX_W-1:0]       ram_rd_addr;
   logic [ppsc_pkg::JOB_W-1:0] ram_rd_data;
   ppsc_pkg::job_type      rd_job;

   logic                   req_fire;
   logic                   issue;
   logic                   cand_ready;
   logic                   cand_better;
   logic [15:0]            rem_dec;
   logic [TW:0]            wt_diff;
   logic [IDX_W+SW-1:0]    slot_wide;

   ppsc_ram #(
      .WIDTH (ppsc_pkg::JOB_W),
      .DEPTH (MAX_PROCS)
   ) u_job_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_job),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   assign rd_job      = ppsc_pkg::job_type'(ram_rd_data);
   assign issue       = (scan_ff < job_cnt_ff);
   assign ram_rd_addr = scan_ff[IDX_W-1:0];

   // The slot read last cycle competes when it is unfinished and has arrived.
   // Slots are scanned upward, so strict compares keep the lower slot when prio and arrival both tie.
   assign cand_ready  = cmp_v_ff && !done_ff[cmp_idx_ff] &&
                        ({16'd0, rd_job.arrival} <= now_ff);
   assign cand_better = !found_ff || (rd_job.prio > best_ff.prio) ||
                        ((rd_job.prio == best_ff.prio) &&
                         (rd_job.arrival < best_ff.arrival));

   assign rem_dec   = best_ff.remaining - 16'd1;
   assign wt_diff   = {1'b0, res_tat_ff} - {{(TW - 15){1'b0}}, best_ff.burst};
   assign slot_wide = (IDX_W + SW)'(res_idx_ff);

   always_comb begin
      state_in      = state_ff;
      job_cnt_in    = job_cnt_ff;
      done_cnt_in   = done_cnt_ff;
      now_in        = now_ff;
      nxt_in        = nxt_ff;
      done_in       = done_ff;
      scan_in       = scan_ff;
      cmp_v_in      = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      found_in      = found_ff;
      best_idx_in   = best_idx_ff;
      best_in       = best_ff;
      res_status_in = res_status_ff;
      res_idx_in    = res_idx_ff;
      res_fin_in    = res_fin_ff;
      res_tat_in    = res_tat_ff;
      res_wt_in     = res_wt_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = job_cnt_ff[IDX_W-1:0];
      ram_wr_job    = best_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               res_idx_in = '0;
               res_fin_in = '0;
               res_tat_in = '0;
               res_wt_in  = '0;
               if (ppsc_pkg::cmd_type'(req_tuser) == ppsc_pkg::CMD_TICK) begin
                  nxt_in   = (now_ff == {TW{1'b1}}) ? now_ff : now_ff + TW'(1);
                  scan_in  = '0;
                  found_in = 1'b0;
                  state_in = S_SCAN;
               end else begin
                  state_in = S_OUT;
                  if (job_cnt_ff == CNT_W'(MAX_PROCS)) begin
                     res_status_in = ppsc_pkg::STATUS_FULL;
                  end else if (req_tdata[31:16] == 16'd0) begin
                     res_status_in = ppsc_pkg::STATUS_ZERO;
                  end else begin
                     ram_wr_en            = 1'b1;
                     ram_wr_job.arrival   = req_tdata[15:0];
                     ram_wr_job.burst     = req_tdata[31:16];
                     ram_wr_job.remaining = req_tdata[31:16];
                     ram_wr_job.prio      = req_tdata[47:32];
                     done_in[job_cnt_ff[IDX_W-1:0]] = 1'b0;
                     job_cnt_in    = job_cnt_ff + CNT_W'(1);
                     res_idx_in    = job_cnt_ff[IDX_W-1:0];
                     res_status_in = ppsc_pkg::STATUS_LOADED;
                  end
               end
            end
         end
         S_SCAN: begin
            cmp_v_in   = issue;
            cmp_idx_in = scan_ff[IDX_W-1:0];
            scan_in    = scan_ff + CNT_W'(issue);
            if (cand_ready && cand_better) begin
               found_in    = 1'b1;
               best_idx_in = cmp_idx_ff;
               best_in     = rd_job;
            end
            if (!issue && !cmp_v_ff) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            now_in   = nxt_ff;
            state_in = S_OUT;
            if (!found_ff) begin
               res_status_in = ppsc_pkg::STATUS_IDLE;
            end else begin
               ram_wr_en         = 1'b1;
               ram_wr_addr       = best_idx_ff;
               ram_wr_job.remaining = rem_dec;
               res_idx_in        = best_idx_ff;
               if (rem_dec == 16'd0) begin
                  done_in[best_idx_ff] = 1'b1;
                  done_cnt_in   = done_cnt_ff + CNT_W'(1);
                  res_status_in = ppsc_pkg::STATUS_COMPLETED;
                  res_fin_in    = nxt_ff;
                  res_tat_in    = nxt_ff - {16'd0, best_ff.arrival};
                  state_in      = S_WAIT;
               end else begin
                  res_status_in = ppsc_pkg::STATUS_RAN;
               end
            end
         end
         S_WAIT: begin
            // A borrow means turnaround fell below the burst, so waiting is zero.
            res_wt_in = wt_diff[TW] ? '0 : wt_diff[TW-1:0];
            state_in  = S_OUT;
         end
         S_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tuser_in  = res_status_ff;
               rsp_tdata_in  = {3'd0, (done_cnt_ff == job_cnt_ff), res_wt_ff,
                                res_tat_ff, res_fin_ff, slot_wide[SW-1:0]};
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         job_cnt_ff    <= '0;
         done_cnt_ff   <= '0;
         now_ff        <= '0;
         done_ff       <= '0;
         cmp_v_ff      <= 1'b0;
         found_ff      <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         job_cnt_ff    <= job_cnt_in;
         done_cnt_ff   <= done_cnt_in;
         now_ff        <= now_in;
         done_ff       <= done_in;
         cmp_v_ff      <= cmp_v_in;
         found_ff      <= found_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      nxt_ff        <= nxt_in;
      scan_ff       <= scan_in;
      cmp_idx_ff    <= cmp_idx_in;
      best_idx_ff   <= best_idx_in;
      best_ff       <= best_in;
      res_status_ff <= res_status_in;
      res_idx_ff    <= res_idx_in;
      res_fin_ff    <= res_fin_in;
      res_tat_ff    <= res_tat_in;
      res_wt_ff     <= res_wt_in;
      rsp_tdata_ff  <= rsp_tdata_in;
      rsp_tuser_ff  <= rsp_tuser_in;
   end

   `PPSC_ASSERT_SAME(a_done_le_jobs, clock, reset, 1'b1, done_cnt_ff <= job_cnt_ff, "more completions than loaded jobs")
   `PPSC_ASSERT_SAME(a_jobs_bounded, clock, reset, 1'b1, job_cnt_ff <= CNT_W'(MAX_PROCS), "job count beyond table size")
   `PPSC_ASSERT_SAME(a_run_unfinished, clock, reset, (state_ff == S_EXEC) && found_ff, !done_ff[best_idx_ff], "selected job is already finished")
   `PPSC_ASSERT_NEXT(a_time_step, clock, reset, state_ff == S_EXEC, (now_ff == $past(now_ff) + TW'(1)) || ($past(now_ff) == {TW{1'b1}}), "time did not advance by one tick")

endmodule
